// ===== rtl/core/particle_mass_deposition_assert.svh =====
// Assertion macros shared by the particle mass deposition RTL.
// Each macro expects i_clk and i_rst_n to be in scope in the using module.
`ifndef PARTICLE_MASS_DEPOSITION_ASSERT_SVH
`define PARTICLE_MASS_DEPOSITION_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PMD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PMD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/pmd_pkg.sv =====
// Shared types, codes and constants of the particle mass deposition block.
// Used by pmd_axis_unit, pmd_grid_mem and particle_mass_deposition.
`default_nettype none
package pmd_pkg;

    localparam int GRID_SIZE_DEF = 16;

    localparam logic [1:0] MODE_DEPOSIT = 2'd0;
    localparam logic [1:0] MODE_CLEAR   = 2'd1;
    localparam logic [1:0] MODE_READ    = 2'd2;
    localparam logic [1:0] MODE_UNDEF   = 2'd3;

    localparam logic [1:0] SCHEME_NGP   = 2'd0;
    localparam logic [1:0] SCHEME_CIC   = 2'd1;
    localparam logic [1:0] SCHEME_TSC   = 2'd2;
    localparam logic [1:0] SCHEME_UNDEF = 2'd3;

    localparam logic [2:0] CFG_SCHEME  = 3'd0;
    localparam logic [2:0] CFG_UNIT    = 3'd1;
    localparam logic [2:0] CFG_PMASK   = 3'd2;
    localparam logic [2:0] CFG_PSIZE_X = 3'd3;
    localparam logic [2:0] CFG_PSIZE_Y = 3'd4;
    localparam logic [2:0] CFG_PSIZE_Z = 3'd5;
    localparam logic [2:0] CFG_SCALE   = 3'd6;

    localparam logic [1:0]  RST_SCHEME = SCHEME_CIC;
    localparam logic [10:0] RST_PSIZE  = 11'd16;
    localparam logic [31:0] RST_SCALE  = 32'd65536;

    localparam logic [16:0] ONE_Q16  = 17'd65536;
    localparam logic [15:0] HALF_Q16 = 16'd32768;

    typedef enum logic [1:0] {
        AX_IDLE,
        AX_SQ,
        AX_DIV,
        AX_FIN
    } t_axis_state;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_AXIS_GO,
        ST_AXIS_WAIT,
        ST_ACC,
        ST_DRAIN,
        ST_READ,
        ST_RDWAIT
    } t_state;

    typedef struct packed {
        logic add;
        logic rd;
        logic clr;
        logic sat;
    } t_grid_ctl;

endpackage
`default_nettype wire

// ===== rtl/core/particle_mass_deposition.sv =====
// Top level of the particle mass deposition block: channels, configuration,
// sequencer and weight multiply pipeline. Uses pmd_pkg, pmd_axis_unit, pmd_grid_mem.
//
// Channel   Dir  Words carried
// s_axis    in   deposit, clear or read command with position, mass, cell index
// m_axis    out  cell value and saturation mark, one word per read command
// cfg       in   register writes, index and data, no handshake
//
// A deposit takes three axis passes of the per-axis unit (with a bit-serial
// remainder pass when the axis wraps), then visits each cell (1, 8 or 27) through
// the single grid memory port, then drains the weight multiply pipeline.
// A clear, and the pass after reset, write all GRID_SIZE^3 cells (4096 by default).
// A read waits while the previous result word is not taken.
`default_nettype none
`include "particle_mass_deposition_assert.svh"
module particle_mass_deposition #(
    parameter int GRID_SIZE = pmd_pkg::GRID_SIZE_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // pos_x, pos_y, pos_z, mass, cell_index, zero pad
    input  wire logic [143:0] s_axis_tdata,
    // mode, is_tracer
    input  wire logic [2:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // cell_value
    output logic [31:0]       m_axis_tdata,
    // saturated
    output logic [0:0]        m_axis_tuser,
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_idx,
    input  wire logic [31:0]  i_cfg_data
);

    localparam int CELLS = GRID_SIZE * GRID_SIZE * GRID_SIZE;
    localparam int AW = $clog2(CELLS);
    localparam int XW = $clog2(GRID_SIZE);

    pmd_pkg::t_state r_state, n_state;

    logic [1:0]  r_scheme;
    logic        r_unit;
    logic [2:0]  r_pmask;
    logic [10:0] r_psize [3];
    logic [31:0] r_scale;

    logic [31:0] r_pos [3];
    logic [31:0] r_mass;
    logic [11:0] r_cidx;
    logic [1:0]  r_axis;
    logic [1:0]  r_n;
    logic [1:0]  r_ci, r_cj, r_ck;
    logic [AW-1:0] r_clr_cnt;

    logic [63:0] r_dprod;
    logic [31:0] r_dens;
    logic        r_dsat;

    logic [16:0]   r_w   [3][3];
    logic [XW-1:0] r_ix  [3][3];
    logic          r_ok  [3][3];

    logic          r_s1_vld, r_s2_vld, r_s3_vld;
    logic          r_s1_ok, r_s2_ok, r_s3_ok;
    logic [AW-1:0] r_s1_addr, r_s2_addr, r_s3_addr;
    logic [16:0]   r_s1_wy, r_s1_wz, r_s2_wz;
    logic [48:0]   r_s1_p, r_s2_p, r_s3_p;

    logic        r_out_vld;
    logic [31:0] r_out_val;
    logic        r_out_sat;

    logic        accept;
    logic [1:0]  in_mode;
    logic        axis_start;
    logic        axis_done;
    logic [XW-1:0] ax_idx [3];
    logic        ax_ok [3];
    logic [16:0] ax_w [3];
    logic        last_cell;
    logic        pipe_empty;
    logic        out_free;
    logic        rd_in_range;
    logic [47:0] dens_rnd;
    logic [48:0] rnd1, rnd2, rnd3;
    logic [AW-1:0] cell_addr;

    pmd_pkg::t_grid_ctl grid_ctl;
    logic [AW-1:0] grid_addr;
    logic [32:0]   grid_rdata;
    logic          grid_busy;

    pmd_axis_unit #(.GRID_SIZE(GRID_SIZE)) u_axis (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (axis_start),
        .i_raw    (r_pos[r_axis]),
        .i_scheme (r_scheme),
        .i_wrap   (r_pmask[r_axis]),
        .i_size   (r_psize[r_axis]),
        .o_done   (axis_done),
        .o_idx    (ax_idx),
        .o_ok     (ax_ok),
        .o_w      (ax_w)
    );

    pmd_grid_mem #(.GRID_SIZE(GRID_SIZE)) u_grid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (grid_ctl),
        .i_addr   (grid_addr),
        .i_amount (rnd3[47:16]),
        .o_rdata  (grid_rdata),
        .o_busy   (grid_busy)
    );

    always_comb begin
        in_mode     = s_axis_tuser[1:0];
        accept      = s_axis_tvalid && s_axis_tready;
        last_cell   = (r_ci == r_n - 2'd1) && (r_cj == r_n - 2'd1) && (r_ck == r_n - 2'd1);
        pipe_empty  = !r_s1_vld && !r_s2_vld && !r_s3_vld && !grid_busy;
        out_free    = !r_out_vld || m_axis_tready;
        rd_in_range = 32'(r_cidx) < 32'(CELLS);
        dens_rnd    = 48'(({r_dprod} + 64'd32768) >> 16);
        rnd1        = r_s1_p + 49'd32768;
        rnd2        = r_s2_p + 49'd32768;
        rnd3        = r_s3_p + 49'd32768;
        cell_addr   = AW'(r_ix[2][r_ck]) * AW'(GRID_SIZE * GRID_SIZE)
                    + AW'(r_ix[1][r_cj]) * AW'(GRID_SIZE) + AW'(r_ix[0][r_ci]);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pmd_pkg::ST_CLEAR: if (r_clr_cnt == AW'(CELLS - 1)) n_state = pmd_pkg::ST_IDLE;
            pmd_pkg::ST_IDLE: begin
                if (accept) begin
                    case (in_mode)
                        pmd_pkg::MODE_DEPOSIT: begin
                            if (!s_axis_tuser[2] && r_scheme != pmd_pkg::SCHEME_UNDEF) begin
                                n_state = pmd_pkg::ST_AXIS_GO;
                            end
                        end
                        pmd_pkg::MODE_CLEAR: n_state = pmd_pkg::ST_CLEAR;
                        pmd_pkg::MODE_READ:  n_state = pmd_pkg::ST_READ;
                        default:             n_state = pmd_pkg::ST_IDLE;
                    endcase
                end
            end
            pmd_pkg::ST_AXIS_GO: n_state = pmd_pkg::ST_AXIS_WAIT;
            pmd_pkg::ST_AXIS_WAIT: begin
                if (axis_done) begin
                    n_state = (r_axis == 2'd2) ? pmd_pkg::ST_ACC : pmd_pkg::ST_AXIS_GO;
                end
            end
            pmd_pkg::ST_ACC:    if (last_cell) n_state = pmd_pkg::ST_DRAIN;
            pmd_pkg::ST_DRAIN:  if (pipe_empty) n_state = pmd_pkg::ST_IDLE;
            pmd_pkg::ST_READ:   n_state = pmd_pkg::ST_RDWAIT;
            pmd_pkg::ST_RDWAIT: if (out_free) n_state = pmd_pkg::ST_IDLE;
            default:            n_state = pmd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == pmd_pkg::ST_IDLE);
        axis_start    = (r_state == pmd_pkg::ST_AXIS_GO);
        grid_ctl.clr  = (r_state == pmd_pkg::ST_CLEAR);
        grid_ctl.rd   = (r_state == pmd_pkg::ST_READ) && rd_in_range;
        grid_ctl.add  = r_s3_vld && r_s3_ok;
        grid_ctl.sat  = r_dsat;
        case (r_state)
            pmd_pkg::ST_CLEAR: grid_addr = r_clr_cnt;
            pmd_pkg::ST_READ:  grid_addr = AW'(r_cidx);
            default:           grid_addr = r_s3_addr;
        endcase
        m_axis_tvalid   = r_out_vld;
        m_axis_tdata    = r_out_val;
        m_axis_tuser[0] = r_out_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pmd_pkg::ST_CLEAR;
            r_clr_cnt <= '0;
            r_out_vld <= 1'b0;
            r_scheme  <= pmd_pkg::RST_SCHEME;
            r_unit    <= 1'b0;
            r_pmask   <= 3'd0;
            r_psize   <= '{pmd_pkg::RST_PSIZE, pmd_pkg::RST_PSIZE, pmd_pkg::RST_PSIZE};
            r_scale   <= pmd_pkg::RST_SCALE;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == pmd_pkg::ST_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end else begin
                r_clr_cnt <= '0;
            end
            if (r_state == pmd_pkg::ST_RDWAIT && out_free) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pmd_pkg::CFG_SCHEME:  r_scheme   <= i_cfg_data[1:0];
                    pmd_pkg::CFG_UNIT:    r_unit     <= i_cfg_data[0];
                    pmd_pkg::CFG_PMASK:   r_pmask    <= i_cfg_data[2:0];
                    pmd_pkg::CFG_PSIZE_X: r_psize[0] <= i_cfg_data[10:0];
                    pmd_pkg::CFG_PSIZE_Y: r_psize[1] <= i_cfg_data[10:0];
                    pmd_pkg::CFG_PSIZE_Z: r_psize[2] <= i_cfg_data[10:0];
                    pmd_pkg::CFG_SCALE:   r_scale    <= i_cfg_data;
                    default: ;
                endcase
            end
            r_s1_vld <= (r_state == pmd_pkg::ST_ACC);
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pos[0] <= s_axis_tdata[31:0];
            r_pos[1] <= s_axis_tdata[63:32];
            r_pos[2] <= s_axis_tdata[95:64];
            r_mass   <= s_axis_tdata[127:96];
            r_cidx   <= s_axis_tdata[139:128];
            r_axis   <= 2'd0;
            r_ci     <= 2'd0;
            r_cj     <= 2'd0;
            r_ck     <= 2'd0;
            case (r_scheme)
                pmd_pkg::SCHEME_NGP: r_n <= 2'd1;
                pmd_pkg::SCHEME_CIC: r_n <= 2'd2;
                default:             r_n <= 2'd3;
            endcase
        end
        if (r_state == pmd_pkg::ST_AXIS_WAIT && axis_done) begin
            r_w[r_axis]  <= ax_w;
            r_ix[r_axis] <= ax_idx;
            r_ok[r_axis] <= ax_ok;
            r_axis       <= r_axis + 2'd1;
        end
        if (r_state == pmd_pkg::ST_ACC) begin
            if (r_ci != r_n - 2'd1) begin
                r_ci <= r_ci + 2'd1;
            end else begin
                r_ci <= 2'd0;
                if (r_cj != r_n - 2'd1) begin
                    r_cj <= r_cj + 2'd1;
                end else begin
                    r_cj <= 2'd0;
                    r_ck <= r_ck + 2'd1;
                end
            end
        end

        r_dprod <= r_mass * r_scale;
        if (r_unit) begin
            r_dens <= 32'd65536;
            r_dsat <= 1'b0;
        end else if (dens_rnd[47:32] != 16'd0) begin
            r_dens <= 32'hFFFF_FFFF;
            r_dsat <= 1'b1;
        end else begin
            r_dens <= dens_rnd[31:0];
            r_dsat <= 1'b0;
        end

        r_s1_p    <= r_dens * r_w[0][r_ci];
        r_s1_wy   <= r_w[1][r_cj];
        r_s1_wz   <= r_w[2][r_ck];
        r_s1_ok   <= r_ok[0][r_ci] && r_ok[1][r_cj] && r_ok[2][r_ck];
        r_s1_addr <= cell_addr;
        r_s2_p    <= rnd1[47:16] * r_s1_wy;
        r_s2_wz   <= r_s1_wz;
        r_s2_ok   <= r_s1_ok;
        r_s2_addr <= r_s1_addr;
        r_s3_p    <= rnd2[47:16] * r_s2_wz;
        r_s3_ok   <= r_s2_ok;
        r_s3_addr <= r_s2_addr;

        if (r_state == pmd_pkg::ST_RDWAIT && out_free) begin
            r_out_val <= rd_in_range ? grid_rdata[31:0] : 32'd0;
            r_out_sat <= rd_in_range ? grid_rdata[32] : 1'b0;
        end
    end

    `PMD_ASSERT_NOW(a_cell_count, r_state == pmd_pkg::ST_ACC, r_ck < r_n && r_cj < r_n && r_ci < r_n, "cell counter overrun")
    `PMD_ASSERT_NOW(a_read_after_drain, r_state == pmd_pkg::ST_READ, !grid_busy && !r_s3_vld, "read while accumulating")
    `PMD_ASSERT_NEXT(a_result_held, r_out_vld && !m_axis_tready, r_out_vld && $stable(r_out_val), "result word lost")

endmodule
`default_nettype wire

// ===== rtl/core/pmd_axis_unit.sv =====
// Per-axis cell and weight unit: splits a position, wraps it when enabled with a
// bit-serial remainder and gives the cell indices and Q1.16 weights. Depends on pmd_pkg.
`default_nettype none
module pmd_axis_unit #(
    parameter int GRID_SIZE = pmd_pkg::GRID_SIZE_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [31:0]                   i_raw,
    input  wire logic [1:0]                    i_scheme,
    input  wire logic                          i_wrap,
    input  wire logic [10:0]                   i_size,
    output logic                               o_done,
    output logic [$clog2(GRID_SIZE)-1:0]       o_idx [3],
    output logic                               o_ok  [3],
    output logic [16:0]                        o_w   [3]
);

    localparam int XW = $clog2(GRID_SIZE);

    pmd_pkg::t_axis_state r_state, n_state;

    logic [17:0] r_c;
    logic [15:0] r_f;
    logic [16:0] r_mag;
    logic [10:0] r_rem;
    logic [4:0]  r_bit;
    logic [1:0]  r_scheme;
    logic        r_wrap;
    logic [10:0] r_size;
    logic [33:0] r_sqa;
    logic [31:0] r_sqf;

    logic [33:0] b;
    logic [17:0] c_new;
    logic [15:0] shift;
    logic [16:0] a;
    logic [11:0] rem_sh;
    logic [11:0] rem_sub;
    logic [10:0] m;
    logic [18:0] ic, im, ip;
    logic [18:0] sel [3];
    logic [16:0] wl, wr, wc;

    always_comb begin
        shift = (i_scheme == pmd_pkg::SCHEME_CIC) ? pmd_pkg::HALF_Q16 : 16'd0;
        b = {2'b00, i_raw ^ 32'h8000_0000} + 34'h1_0000_0000 - {18'd0, shift};
        c_new = {1'b0, b[32:16]} - 18'd98304;
        a = pmd_pkg::ONE_Q16 - {1'b0, r_f};
        rem_sh = {r_rem, r_mag[r_bit]};
        rem_sub = rem_sh - {1'b0, r_size};
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pmd_pkg::AX_IDLE: if (i_start) n_state = pmd_pkg::AX_SQ;
            pmd_pkg::AX_SQ:   n_state = r_wrap ? pmd_pkg::AX_DIV : pmd_pkg::AX_FIN;
            pmd_pkg::AX_DIV:  if (r_bit == 5'd0) n_state = pmd_pkg::AX_FIN;
            pmd_pkg::AX_FIN:  n_state = pmd_pkg::AX_IDLE;
            default:          n_state = pmd_pkg::AX_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_state == pmd_pkg::AX_FIN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pmd_pkg::AX_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sqa <= a * a;
        r_sqf <= r_f * r_f;
        if (r_state == pmd_pkg::AX_IDLE && i_start) begin
            r_c      <= c_new;
            r_f      <= b[15:0];
            r_mag    <= c_new[17] ? 17'(-c_new) : c_new[16:0];
            r_rem    <= 11'd0;
            r_bit    <= 5'd16;
            r_scheme <= i_scheme;
            r_wrap   <= i_wrap && (i_size != 11'd0);
            r_size   <= i_size;
        end else if (r_state == pmd_pkg::AX_DIV) begin
            r_rem <= rem_sh >= {1'b0, r_size} ? rem_sub[10:0] : rem_sh[10:0];
            r_bit <= r_bit - 5'd1;
        end
    end

    always_comb begin
        m = (r_c[17] && r_rem != 11'd0) ? r_size - r_rem : r_rem;
        if (r_wrap) begin
            ic = {8'd0, m};
            im = (m == 11'd0) ? {8'd0, r_size - 11'd1} : {8'd0, m - 11'd1};
            ip = (m + 11'd1 == r_size) ? 19'd0 : {8'd0, m + 11'd1};
        end else begin
            ic = {r_c[17], r_c};
            im = {r_c[17], r_c} - 19'd1;
            ip = {r_c[17], r_c} + 19'd1;
        end
        wl = 17'((r_sqa + 34'd65536) >> 17);
        wr = 17'(({2'b00, r_sqf} + 34'd65536) >> 17);
        wc = pmd_pkg::ONE_Q16 - wl - wr;
        case (r_scheme)
            pmd_pkg::SCHEME_NGP: begin
                sel[0] = ic; sel[1] = ip; sel[2] = ip;
                o_w[0] = pmd_pkg::ONE_Q16; o_w[1] = 17'd0; o_w[2] = 17'd0;
            end
            pmd_pkg::SCHEME_CIC: begin
                sel[0] = ic; sel[1] = ip; sel[2] = ip;
                o_w[0] = a; o_w[1] = {1'b0, r_f}; o_w[2] = 17'd0;
            end
            default: begin
                sel[0] = im; sel[1] = ic; sel[2] = ip;
                o_w[0] = wl; o_w[1] = wc; o_w[2] = wr;
            end
        endcase
        for (int i = 0; i < 3; i++) begin
            o_ok[i]  = !sel[i][18] && (sel[i] < 19'(GRID_SIZE));
            o_idx[i] = sel[i][XW-1:0];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/pmd_grid_mem.sv =====
// Density grid store: one memory of value and saturation mark per cell, with
// read-modify-write accumulation, forwarding and clear writes. Uses pmd_pkg.
`default_nettype none
`include "particle_mass_deposition_assert.svh"
module pmd_grid_mem #(
    parameter int GRID_SIZE = pmd_pkg::GRID_SIZE_DEF
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire pmd_pkg::t_grid_ctl                          i_ctl,
    input  wire logic [$clog2(GRID_SIZE*GRID_SIZE*GRID_SIZE)-1:0] i_addr,
    input  wire logic [31:0]                                 i_amount,
    output logic [32:0]                                      o_rdata,
    output logic                                             o_busy
);

    localparam int CELLS = GRID_SIZE * GRID_SIZE * GRID_SIZE;
    localparam int AW = $clog2(CELLS);

    logic [32:0] mem [CELLS];

    logic [32:0]   r_rdata;
    logic          r_pend;
    logic [AW-1:0] r_paddr;
    logic [31:0]   r_pamt;
    logic          r_psat;
    logic          r_fwd_vld;
    logic [AW-1:0] r_fwd_addr;
    logic [32:0]   r_fwd_data;

    logic [32:0] old;
    logic [32:0] sum;
    logic [32:0] upd;

    always_comb begin
        old = (r_fwd_vld && r_fwd_addr == r_paddr) ? r_fwd_data : r_rdata;
        sum = {1'b0, old[31:0]} + {1'b0, r_pamt};
        upd = {old[32] | sum[32] | r_psat, sum[32] ? 32'hFFFF_FFFF : sum[31:0]};
        o_rdata = r_rdata;
        o_busy = r_pend;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd || i_ctl.add) begin
            r_rdata <= mem[i_addr];
        end
        if (i_ctl.clr) begin
            mem[i_addr] <= 33'd0;
        end else if (r_pend) begin
            mem[r_paddr] <= upd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_paddr    <= i_addr;
        r_pamt     <= i_amount;
        r_psat     <= i_ctl.sat;
        r_fwd_addr <= r_paddr;
        r_fwd_data <= upd;
        if (!i_rst_n) begin
            r_pend    <= 1'b0;
            r_fwd_vld <= 1'b0;
        end else begin
            r_pend    <= i_ctl.add;
            r_fwd_vld <= r_pend;
        end
    end

    `PMD_ASSERT_NOW(a_no_clr_during_add, i_ctl.clr, !i_ctl.add && !r_pend, "clear overlaps accumulate")
    `PMD_ASSERT_NEXT(a_fwd_follows_write, r_pend, r_fwd_vld && r_fwd_addr == $past(r_paddr), "forward lost")
    `PMD_ASSERT_NOW(a_no_read_during_add, i_ctl.rd, !r_pend && !i_ctl.add, "read overlaps accumulate")

endmodule
`default_nettype wire
